// ===== rtl/core/ms_pkg.sv =====
package ms_pkg;

	// One stored element: the data word and whether the slot is occupied.
	typedef logic signed [31:0] ms_data_t;

	typedef struct packed {
		logic     valid;
		ms_data_t data;
	} ms_slot_t;

	// Operation broadcast to every cell of the chain at once.
	typedef struct packed {
		logic insert;
		logic shift;
	} ms_ctl_t;

endpackage

// ===== rtl/core/ms_cell.sv =====
module ms_cell
	import ms_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  ms_ctl_t  ctl,
	input  ms_data_t new_value,
	input  ms_slot_t left_slot,
	input  logic     left_take,
	input  ms_slot_t right_slot,
	output ms_slot_t slot,
	output logic     take
);

	logic     valid_q;
	ms_data_t data_q;

	// An empty slot ranks above every value, so the new value settles in the
	// first empty slot or before the first stored value greater than it.
	assign take = !valid_q || (new_value < data_q);
	assign slot = '{valid: valid_q, data: data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.insert && take) begin
			valid_q <= left_take ? left_slot.valid : 1'b1;
		end else if (ctl.shift) begin
			valid_q <= right_slot.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert && take) begin
			data_q <= left_take ? left_slot.data : new_value;
		end else if (ctl.shift) begin
			data_q <= right_slot.data;
		end
	end

endmodule

// ===== rtl/core/merge_sorter.sv =====
// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+-----------------------
// item      | in        | item_valid / item_ready  | value[31:0], last
// res       | out       | res_valid / res_ready    | sorted_value[31:0], last_res
//
// Each accepted request is loaded as it is taken: while the last cell is free,
// the chain of cells places the new value in sorted position at the same edge.
// Each result leaves as it is taken: the chain shifts toward cell 0 at that edge.
// While a set drains, no new request is taken; stalls on res hold the chain.
// Reset clears the occupancy bits of all cells and returns to loading.
module merge_sorter
	import ms_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [31:0] value,
	input  logic        last,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [31:0] sorted_value,
	output logic        last_res
);

	// Loading takes requests; draining emits the sorted set.
	localparam logic ST_LOAD  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic     state_q;
	logic     in_acc;
	logic     out_acc;
	logic     full;
	ms_ctl_t  ctl;
	ms_slot_t slots [MAX_ITEMS];
	logic     takes [MAX_ITEMS];

	assign item_ready = (state_q == ST_LOAD);
	assign res_valid  = (state_q == ST_DRAIN);
	assign in_acc     = item_valid && item_ready;
	assign out_acc    = res_valid && res_ready;

	// The set is full once the last cell holds a value; further values are
	// dropped, though a closing flag still ends the set.
	assign full = slots[MAX_ITEMS-1].valid;
	assign ctl  = '{insert: in_acc && !full, shift: out_acc};

	// The smallest value always sits in cell 0; the final one is reached
	// when cell 1 is empty.
	assign sorted_value = slots[0].data;
	assign last_res     = !slots[1].valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc && last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (out_acc && last_res) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// The row of cells: each sees its left neighbor's slot and decision for
	// insertion, and its right neighbor's slot for draining.
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		ms_slot_t left_slot;
		logic     left_take;
		ms_slot_t right_slot;

		if (i == 0) begin : g_first
			assign left_slot = '0;
			assign left_take = 1'b0;
		end else begin : g_mid
			assign left_slot = slots[i-1];
			assign left_take = takes[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_last
			assign right_slot = '0;
		end else begin : g_inner
			assign right_slot = slots[i+1];
		end

		ms_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_value  (ms_data_t'(value)),
			.left_slot  (left_slot),
			.left_take  (left_take),
			.right_slot (right_slot),
			.slot       (slots[i]),
			.take       (takes[i])
		);
	end

	// While draining, cell 0 always holds a value to send.
	a_drain_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> slots[0].valid)
		else $error("drain phase with empty head cell");

	// A closing request starts the drain at the next edge.
	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last) |=> res_valid)
		else $error("closing request did not start drain");

	// The final result returns the block to loading with an empty chain.
	a_drain_ends_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_res) |=> (item_ready && !slots[0].valid))
		else $error("chain not empty after final result");

	// Loading and draining never overlap.
	a_phase_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(item_ready && res_valid))
		else $error("request and result sides active together");

endmodule

// ===== tb/tb_merge_sorter.sv =====
// Testbench for merge_sorter.
//
// Requests carry one signed element each. A request flagged last closes the
// set, and the block answers with the whole stored set in ascending order,
// one element per result, with last_res on the final one. Elements that
// arrive while the store already holds a full set are dropped. A closing
// request is still honored when its element is dropped.
//
// The testbench keeps its own copy of the set being collected. When a set
// closes, it orders the set and queues the expected results. A checker
// process compares every result taken from the block with the oldest
// expectation. The sender works in bursts with random gaps except in the
// steady stream test. The receiver stalls on a pattern that each test
// selects. A watchdog ends the run when neither channel moves for too long.
module tb_merge_sorter;
	import ms_pkg::*;

	localparam int SET_CAPACITY = 64;
	// No legal wait between two handshakes comes close to this.
	localparam int STALL_LIMIT = 4000;
	// Cycles to watch for stray results once nothing is expected.
	localparam int SETTLE_CYCLES = 32;

	typedef enum {RX_FREE, RX_RANDOM, RX_BURSTY} rx_mode_t;

	typedef struct {
		ms_data_t data;
		logic     last;
	} sorted_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [31:0] value = '0;
	logic        last = 1'b0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [31:0] sorted_value;
	logic        last_res;

	// Prediction state: the set as it is collected, and the ordered results
	// that have not come back from the block yet.
	ms_data_t     set_held[$];
	sorted_word_t expected_sorted[$];

	int       fail_count = 0;
	int       idle_cycles = 0;
	int       burst_left = 0;
	bit       sender_bursty = 1'b1;
	rx_mode_t rx_mode = RX_FREE;
	int       rx_run = 0;
	int       rx_stall = 0;

	merge_sorter #(
		.MAX_ITEMS(SET_CAPACITY)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.value       (value),
		.last        (last),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.sorted_value(sorted_value),
		.last_res    (last_res)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The element is stored while there is room. A closing request orders
	// the set and queues one expectation per element. Equal elements are
	// placed after the ones already there, so the order is stable.
	task automatic absorb_request(input ms_data_t elem, input logic closes);
		ms_data_t ordered[$];
		int       pos;
		if (set_held.size() < SET_CAPACITY)
			set_held.push_back(elem);
		if (closes) begin
			foreach (set_held[i]) begin
				pos = 0;
				while (pos < ordered.size() && ordered[pos] <= set_held[i])
					pos++;
				ordered.insert(pos, set_held[i]);
			end
			foreach (ordered[k])
				expected_sorted.push_back('{ordered[k], k == ordered.size() - 1});
			set_held.delete();
		end
	endtask

	// Called at a falling edge. Presents one request and holds it until the
	// block takes it. It then returns at a falling edge. Valid stays high
	// unless the burst has ended, so back-to-back requests never see valid
	// lowered and raised within one time step.
	task automatic send_request(input ms_data_t elem, input logic closes);
		item_valid <= 1'b1;
		value      <= elem;
		last       <= closes;
		do
			@(posedge clk);
		while (!item_ready);
		absorb_request(elem, closes);
		@(negedge clk);
		if (sender_bursty) begin
			if (burst_left == 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				burst_left = $urandom_range(1, 16);
			end else begin
				burst_left--;
			end
		end
	endtask

	// The mix favors duplicates and the two extremes of the signed range,
	// since those are the cases that test ties and the signed compare.
	function automatic ms_data_t random_element();
		case ($urandom_range(0, 7))
			0: return ms_data_t'(32'h8000_0000);
			1: return ms_data_t'(32'h7FFF_FFFF);
			2, 3: return ms_data_t'($urandom_range(0, 8)) - 32'sd4;
			default: return ms_data_t'($urandom);
		endcase
	endfunction

	// Sends one closed set of the given size with random content.
	task automatic send_random_set(input int size);
		for (int k = 0; k < size; k++)
			send_request(random_element(), k == size - 1);
	endtask

	// Single-element sets at both ends of the range and at zero.
	task automatic test_single_sets();
		rx_mode = RX_FREE;
		send_request(ms_data_t'(32'h8000_0000), 1'b1);
		send_request(ms_data_t'(32'h7FFF_FFFF), 1'b1);
		send_request(32'sd0, 1'b1);
	endtask

	// Extremes, the sign boundary and repeated values within one set. A
	// reversed run follows, along with a pair of equal elements.
	task automatic test_extremes_and_ties();
		rx_mode = RX_RANDOM;
		send_request(ms_data_t'(32'h7FFF_FFFF), 1'b0);
		send_request(ms_data_t'(32'h8000_0000), 1'b0);
		send_request(32'sd0, 1'b0);
		send_request(-32'sd1, 1'b0);
		send_request(32'sd1, 1'b0);
		send_request(ms_data_t'(32'h8000_0000), 1'b0);
		send_request(ms_data_t'(32'h7FFF_FFFF), 1'b0);
		send_request(32'sd5, 1'b1);
		send_request(32'sd40, 1'b0);
		send_request(32'sd30, 1'b0);
		send_request(-32'sd20, 1'b0);
		send_request(-32'sd100, 1'b1);
		send_request(32'sd7, 1'b0);
		send_request(32'sd7, 1'b1);
	endtask

	// A set that exactly fills the store. The closing request holds the
	// last element that fits.
	task automatic test_full_set();
		rx_mode = RX_BURSTY;
		send_random_set(SET_CAPACITY);
	endtask

	// The store fills first. Three more elements are then dropped, and a
	// closing request whose element is dropped too still ends the set.
	task automatic test_overflow_dropped();
		rx_mode = RX_RANDOM;
		for (int k = 0; k < SET_CAPACITY + 3; k++)
			send_request(random_element(), 1'b0);
		send_request(random_element(), 1'b1);
	endtask

	// Random sets, mostly small and sometimes large, under both kinds of
	// receiver stall.
	task automatic test_random_sets(input int budget);
		int size;
		int sent;
		sent = 0;
		while (sent < budget) begin
			rx_mode = ($urandom_range(0, 1) == 0) ? RX_RANDOM : RX_BURSTY;
			size = ($urandom_range(0, 9) == 0) ? $urandom_range(20, SET_CAPACITY)
			                                   : $urandom_range(1, 12);
			send_random_set(size);
			sent += size;
		end
	endtask

	// Small sets with no idling on either side. This keeps the block at full
	// rate through loading and draining.
	task automatic test_steady_stream();
		sender_bursty = 1'b0;
		rx_mode       = RX_FREE;
		for (int s = 0; s < 6; s++)
			send_random_set($urandom_range(1, 8));
		sender_bursty = 1'b1;
	endtask

	// The receiver drives ready from a pattern of its own. It is held high,
	// set at random each cycle, or run through random stall and run lengths.
	always @(negedge clk) begin
		case (rx_mode)
			RX_FREE:   res_ready <= 1'b1;
			RX_RANDOM: res_ready <= ($urandom_range(0, 2) != 0);
			default: begin
				if (rx_run > 0) begin
					res_ready <= 1'b1;
					rx_run--;
				end else if (rx_stall > 0) begin
					res_ready <= 1'b0;
					rx_stall--;
				end else begin
					rx_run   = $urandom_range(1, 8);
					rx_stall = $urandom_range(1, 24);
					res_ready <= 1'b1;
				end
			end
		endcase
	end

	// Each accepted result is compared with the oldest expectation.
	always @(posedge clk) begin
		sorted_word_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_sorted.size() == 0) begin
				$error("result with no expectation: sorted_value=%0d last_res=%0b",
				       $signed(sorted_value), last_res);
				fail_count++;
			end else begin
				want = expected_sorted.pop_front();
				if (sorted_value !== want.data) begin
					$error("sorted_value: expected %0d, got %0d",
					       want.data, $signed(sorted_value));
					fail_count++;
				end
				if (last_res !== want.last) begin
					$error("last_res: expected %0b, got %0b", want.last, last_res);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: ends the run when neither channel completes a handshake for
	// too long.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (res_valid && res_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		burst_left = $urandom_range(1, 16);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_single_sets();
		test_extremes_and_ties();
		test_full_set();
		test_overflow_dropped();
		test_steady_stream();
		test_random_sets(90);

		// Every set is closed, so all results are already queued. Lower
		// valid, let the block drain, and watch a while longer for any
		// stray result.
		item_valid <= 1'b0;
		rx_mode = RX_RANDOM;
		while (expected_sorted.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0 && expected_sorted.size() == 0 && set_held.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ms_pkg.sv
rtl/core/ms_cell.sv
rtl/core/merge_sorter.sv
tb/tb_merge_sorter.sv
